// ===== rtl/sam_pkg.sv =====
package sam_pkg;

  localparam int SAMPLE_LIMIT = 82880;

  localparam int POS_W     = 18;
  localparam int MAG_W     = 17;
  localparam int AXIS_W    = 16;
  localparam int PROD_W    = 32;
  localparam int QUO_W     = 17;
  localparam int AX_NUM_W  = 34;
  localparam int ANG_NUM_W = 36;
  localparam int TRAV15_W  = 21;

  // trav * 900 * |axis| / (296 * 65535) reduces by 60 to trav * 15 * |axis| / 323306.
  // The divide is a multiply by a rounded-up reciprocal, exact for numerators
  // below 2^36.
  localparam logic [3:0]  DEG_SCALE   = 4'd15;
  localparam int          ANG_NLO_W   = 18;
  localparam int          ANG_RLO_W   = 19;
  localparam int          ANG_RECIP_W = 37;
  localparam int          ANG_SHIFT   = 55;
  localparam int          ANG_SUM_W   = ANG_SHIFT + QUO_W;
  localparam logic [ANG_RECIP_W-1:0] ANG_RECIP =
    ANG_RECIP_W'(((64'd1 << ANG_SHIFT) + 64'd323305) / 64'd323306);

  // quotient by 18000 for the fold, exact for angles below 2^17
  localparam logic [16:0] HALF_TURN    = 17'd18000;
  localparam int          FOLD_RECIP_W = 18;
  localparam int          FOLD_SHIFT   = 32;
  localparam int          FOLD_Q_W     = 3;
  localparam logic [FOLD_RECIP_W-1:0] FOLD_RECIP =
    FOLD_RECIP_W'(((64'd1 << FOLD_SHIFT) + 64'd17999) / 64'd18000);

  typedef enum logic [1:0] {
    REG_CENTER   = 2'd0,
    REG_TRAVEL   = 2'd1,
    REG_DEADBAND = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic                    neg;
    logic                    zero;
    logic                    ovf;
  } ax_side_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos;
    logic signed [AXIS_W-1:0] axis;
    logic                     neg;
  } ang_side_t;

endpackage

// ===== rtl/sam_if.sv =====
interface sam_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] raw_sample;
  modport source(output valid, output raw_sample, input ready);
  modport sink(input valid, input raw_sample, output ready);
endinterface

interface sam_result_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] shaped_position;
  logic signed [15:0] signed_axis;
  logic        [15:0] unsigned_axis;
  logic signed [15:0] display_angle;
  modport source(output valid, output shaped_position, output signed_axis,
                 output unsigned_axis, output display_angle, input ready);
  modport sink(input valid, input shaped_position, input signed_axis,
               input unsigned_axis, input display_angle, output ready);
endinterface

// ===== rtl/steering_axis_mapper.sv =====
// Steering axis mapper: one result per sample, a new sample every cycle.
// The pipe has four front stages (center, saturate, deadband,
// scale), a 17-stage restoring divider by the travel, an axis clamp stage,
// the angle multiply, two reciprocal multiply stages for the display
// constant, a fold quotient stage and the fold/output register. A stall at
// the result port freezes the whole pipe.
// Write travel_limit and deadband_width only while no sample is in flight.
module steering_axis_mapper (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  sam_sample_if.sink          sample,
  sam_result_if.source        result
);
  import sam_pkg::*;

  localparam logic signed [32:0]    LIM33 = 33'(SAMPLE_LIMIT);
  localparam logic [MAG_W-1:0]      LIM17 = MAG_W'(SAMPLE_LIMIT);

  // configuration
  logic signed [31:0]  center_offset;
  logic [16:0]         travel_limit;
  logic [16:0]         deadband_width;
  logic [MAG_W-1:0]    trav_sat;
  logic [MAG_W-1:0]    db_sat;
  logic [TRAV15_W-1:0] trav15;
  reg_idx_t            widx;
  reg_idx_t            ridx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset  <= '0;
      travel_limit   <= '0;
      deadband_width <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_CENTER:   center_offset  <= pwdata;
        REG_TRAVEL:   travel_limit   <= pwdata[16:0];
        REG_DEADBAND: deadband_width <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CENTER:   prdata = center_offset;
      REG_TRAVEL:   prdata = {15'd0, travel_limit};
      REG_DEADBAND: prdata = {15'd0, deadband_width};
      default:      prdata = '0;
    endcase
  end

  assign trav_sat = (travel_limit > LIM17) ? LIM17 : travel_limit;
  assign db_sat   = (deadband_width > LIM17) ? LIM17 : deadband_width;

  always_ff @(posedge clk) begin
    trav15 <= TRAV15_W'(trav_sat * DEG_SCALE);
  end

  // global stall
  logic en;
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // stage 1: center
  logic               v1;
  logic signed [32:0] diff1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      diff1 <= {sample.raw_sample[31], sample.raw_sample} -
               {center_offset[31], center_offset};
    end
  end

  // stage 2: saturate
  logic                    v2;
  logic signed [POS_W-1:0] pos2;
  logic signed [POS_W-1:0] sat_c;
  always_comb begin
    priority if (diff1 > LIM33) begin
      sat_c = POS_W'(LIM33);
    end else if (diff1 < -LIM33) begin
      sat_c = POS_W'(-LIM33);
    end else begin
      sat_c = diff1[POS_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos2 <= sat_c;
    end
  end

  // stage 3: deadband
  logic                    v3;
  logic signed [POS_W-1:0] pos3;
  logic signed [POS_W:0]   p19;
  logic signed [POS_W:0]   db19;
  logic signed [POS_W-1:0] shaped_c;
  assign p19  = {pos2[POS_W-1], pos2};
  assign db19 = {2'b00, db_sat};
  always_comb begin
    priority if (p19 > -db19 && p19 < db19) begin
      shaped_c = '0;
    end else if (p19[POS_W]) begin
      shaped_c = POS_W'(p19 + db19);
    end else begin
      shaped_c = POS_W'(p19 - db19);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos3 <= shaped_c;
    end
  end

  // stage 4: magnitude times scale
  logic                    v4;
  logic signed [POS_W-1:0] pos4;
  logic                    neg4;
  logic [PROD_W-1:0]       prod4;
  logic [POS_W-1:0]        abs_c;
  logic [MAG_W-1:0]        mag_c;
  assign abs_c = pos3[POS_W-1] ? POS_W'(-pos3) : pos3;
  assign mag_c = abs_c[MAG_W-1:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos4  <= pos3;
      neg4  <= pos3[POS_W-1];
      prod4 <= pos3[POS_W-1] ? {mag_c, 15'd0}
                             : {mag_c, 15'd0} - PROD_W'(mag_c);
    end
  end

  // divide by travel
  ax_side_t          ax_in;
  ax_side_t          ax_out;
  logic [AX_NUM_W-1:0] ax_num;
  logic [QUO_W-1:0]  ax_q;
  logic              vd1;
  assign ax_in.pos  = pos4;
  assign ax_in.neg  = neg4;
  assign ax_in.zero = (trav_sat == '0);
  assign ax_in.ovf  = {2'b00, prod4[31:17]} >= trav_sat;
  assign ax_num     = (ax_in.zero || ax_in.ovf) ? '0 : {2'b00, prod4};

  sam_div #(
    .NUM_W (AX_NUM_W),
    .DEN_W (MAG_W),
    .QUO_W (QUO_W),
    .SIDE_W($bits(ax_side_t))
  ) u_ax_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .num      (ax_num),
    .den      (trav_sat),
    .side_in  (ax_in),
    .out_valid(vd1),
    .quo      (ax_q),
    .side_out (ax_out)
  );

  // axis clamp
  logic                     v5;
  logic signed [POS_W-1:0]  pos5;
  logic signed [AXIS_W-1:0] axis5;
  logic [AXIS_W-1:0]        abs5;
  logic                     neg5;
  logic [AXIS_W-1:0]        abs_ax_c;
  always_comb begin
    priority if (ax_out.zero) begin
      abs_ax_c = '0;
    end else if (ax_out.neg) begin
      abs_ax_c = (ax_out.ovf || ax_q > 17'd32768) ? 16'd32768 : ax_q[AXIS_W-1:0];
    end else begin
      abs_ax_c = (ax_out.ovf || ax_q > 17'd32767) ? 16'd32767 : ax_q[AXIS_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vd1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos5  <= ax_out.pos;
      abs5  <= abs_ax_c;
      neg5  <= ax_out.neg;
      axis5 <= ax_out.neg ? AXIS_W'(-abs_ax_c) : abs_ax_c;
    end
  end

  // angle multiply
  logic                       v6;
  logic [ANG_NUM_W-1:0]       a6;
  ang_side_t                  ang6;
  logic [TRAV15_W+AXIS_W-1:0] mul_c;
  assign mul_c = trav15 * abs5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a6        <= mul_c[ANG_NUM_W-1:0];
      ang6.pos  <= pos5;
      ang6.axis <= axis5;
      ang6.neg  <= neg5;
    end
  end

  // reciprocal multiply, split into four partial products
  logic                                   v7;
  ang_side_t                              ang7;
  logic [ANG_NLO_W+ANG_RLO_W-1:0]         pp_ll7;
  logic [ANG_NLO_W+ANG_RECIP_W-ANG_RLO_W-1:0] pp_lh7;
  logic [ANG_NUM_W-ANG_NLO_W+ANG_RLO_W-1:0]   pp_hl7;
  logic [ANG_NUM_W+ANG_RECIP_W-ANG_NLO_W-ANG_RLO_W-1:0] pp_hh7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll7 <= a6[ANG_NLO_W-1:0] * ANG_RECIP[ANG_RLO_W-1:0];
      pp_lh7 <= a6[ANG_NLO_W-1:0] * ANG_RECIP[ANG_RECIP_W-1:ANG_RLO_W];
      pp_hl7 <= a6[ANG_NUM_W-1:ANG_NLO_W] * ANG_RECIP[ANG_RLO_W-1:0];
      pp_hh7 <= a6[ANG_NUM_W-1:ANG_NLO_W] * ANG_RECIP[ANG_RECIP_W-1:ANG_RLO_W];
      ang7   <= ang6;
    end
  end

  // sum partial products, keep the quotient
  logic                 v8;
  ang_side_t            ang8;
  logic [QUO_W-1:0]     r8;
  logic [ANG_SUM_W-1:0] sum_c;
  assign sum_c = ANG_SUM_W'(pp_ll7)
               + (ANG_SUM_W'(pp_lh7) << ANG_RLO_W)
               + (ANG_SUM_W'(pp_hl7) << ANG_NLO_W)
               + (ANG_SUM_W'(pp_hh7) << (ANG_RLO_W + ANG_NLO_W));
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r8   <= sum_c[ANG_SUM_W-1:ANG_SHIFT];
      ang8 <= ang7;
    end
  end

  // count half turns
  logic                          v9;
  ang_side_t                     ang9;
  logic [QUO_W-1:0]              r9;
  logic [FOLD_Q_W-1:0]           k9;
  logic [QUO_W+FOLD_RECIP_W-1:0] fq_c;
  assign fq_c = r8 * FOLD_RECIP;
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r9   <= r8;
      k9   <= fq_c[QUO_W+FOLD_RECIP_W-1:FOLD_SHIFT];
      ang9 <= ang8;
    end
  end

  // fold into half turns
  logic [QUO_W-1:0] fold_rem;
  logic             fold_odd;
  logic [QUO_W-1:0] fold_mag;
  logic             fold_flip;
  logic [QUO_W:0]   fold_val;
  always_comb begin
    fold_rem = r9 - QUO_W'(k9 * HALF_TURN);
    fold_odd = k9[0];
    priority if (r9 <= HALF_TURN) begin
      fold_mag  = r9;
      fold_flip = 1'b0;
    end else if (fold_odd) begin
      fold_mag  = HALF_TURN - fold_rem;
      fold_flip = 1'b1;
    end else begin
      fold_mag  = fold_rem;
      fold_flip = 1'b0;
    end
    fold_val = (ang9.neg ^ fold_flip) ? -{1'b0, fold_mag} : {1'b0, fold_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= v9;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      result.shaped_position <= ang9.pos;
      result.signed_axis     <= ang9.axis;
      result.unsigned_axis   <= {~ang9.axis[AXIS_W-1], ang9.axis[AXIS_W-2:0]};
      result.display_angle   <= fold_val[AXIS_W-1:0];
    end
  end

endmodule

// ===== rtl/sam_div.sv =====
// Restoring divider, one quotient bit per register stage. The caller keeps
// num below den << QUO_W and holds den steady while items are in flight.
module sam_div #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 17,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [QUO_W-1:0]  vld;
  logic [NUM_W-1:0]  rem  [QUO_W];
  logic [QUO_W-1:0]  q    [QUO_W];
  logic [SIDE_W-1:0] sd   [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int K = QUO_W - 1 - i;
    logic              cur_vld;
    logic [NUM_W-1:0]  cur_rem;
    logic [QUO_W-1:0]  cur_q;
    logic [SIDE_W-1:0] cur_sd;
    logic [NUM_W:0]    shifted;
    logic [NUM_W:0]    diff;

    if (i == 0) begin : g_first
      assign cur_vld = in_valid;
      assign cur_rem = num;
      assign cur_q   = '0;
      assign cur_sd  = side_in;
    end else begin : g_next
      assign cur_vld = vld[i-1];
      assign cur_rem = rem[i-1];
      assign cur_q   = q[i-1];
      assign cur_sd  = sd[i-1];
    end

    assign shifted = {{(NUM_W+1-DEN_W){1'b0}}, den} << K;
    assign diff    = {1'b0, cur_rem} - shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= diff[NUM_W] ? cur_rem : diff[NUM_W-1:0];
        q[i]   <= {cur_q[QUO_W-2:0], ~diff[NUM_W]};
        sd[i]  <= cur_sd;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo       = q[QUO_W-1];
  assign side_out  = sd[QUO_W-1];

endmodule
